// ===== hdl/rrd_pkg.sv =====
// Shared types and constants for the radio response deframer.
package rrd_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ACK_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN  = 2'd1;

    localparam logic [7:0] ACK_CODE_RESET = 8'h50;
    localparam logic [7:0] MAX_LEN_RESET  = 8'hFF;

    localparam logic [7:0] EXT_MARK    = 8'hFF;
    localparam logic [7:0] SUM_GOOD    = 8'hFF;
    localparam logic [7:0] EXT_HDR_LEN = 8'd3;
    localparam logic [3:0] NIB_MASK    = 4'hF;
    localparam logic [1:0] HDR_LAST    = 2'd2;

    localparam logic [2:0] ST_OK  = 3'd0;
    localparam logic [2:0] ST_ACK = 3'd1;
    localparam logic [2:0] ST_LEN = 3'd2;
    localparam logic [2:0] ST_SUM = 3'd3;
    localparam logic [2:0] ST_TMO = 3'd4;

    typedef struct packed {
        logic [7:0] ack_code;
        logic [7:0] max_len;
    } rrd_cfg_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       is_status;
        logic [2:0] frame_status;
        logic       last_of_frame;
    } rrd_result_t;

endpackage

// ===== hdl/rrd_cfg.sv =====
// Configuration register bank for the deframer.
module rrd_cfg
    import rrd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    output rrd_cfg_t             cfg
);

    rrd_cfg_t cfg_reg;
    rrd_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ACK_CODE: cfg_next.ack_code = cfg_data;
                CFG_MAX_LEN:  cfg_next.max_len  = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ack_code <= ACK_CODE_RESET;
            cfg_reg.max_len  <= MAX_LEN_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hdl/rrd_parser.sv =====
// Input register and frame parser state machine.
module rrd_parser
    import rrd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  rrd_cfg_t    cfg,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_rx_timeout,
    input  logic        res_ready,
    output logic        res_valid,
    output rrd_result_t res
);

    typedef enum logic [2:0] {
        PH_ACK = 3'd0,
        PH_LEN = 3'd1,
        PH_HDR = 3'd2,
        PH_PAY = 3'd3,
        PH_CHK = 3'd4
    } phase_t;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_tmo_reg;

    phase_t     phase_reg, phase_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] left_reg, left_next;
    logic [1:0] hidx_reg, hidx_next;

    logic        produces;
    rrd_result_t res_c;
    logic        advance;
    logic [7:0]  sum_add;
    logic [7:0]  short_cnt;
    logic [7:0]  left_dec;
    logic [7:0]  ext_body;

    assign sum_add   = sum_reg + in_byte_reg;
    assign short_cnt = {4'b0, in_byte_reg[3:0] & NIB_MASK} + 8'd1;
    assign left_dec  = left_reg - 8'd1;
    assign ext_body  = in_byte_reg - 8'd1;

    always_comb begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        left_next  = left_reg;
        hidx_next  = hidx_reg;
        produces   = 1'b0;
        res_c      = '0;

        if (in_tmo_reg) begin
            produces           = 1'b1;
            res_c.frame_status = ST_TMO;
        end else begin
            unique case (phase_reg)
                PH_LEN: begin
                    sum_next = in_byte_reg;
                    if (in_byte_reg == EXT_MARK) begin
                        if (cfg.max_len < EXT_HDR_LEN) begin
                            produces           = 1'b1;
                            res_c.frame_status = ST_LEN;
                        end else begin
                            hidx_next  = 2'd0;
                            phase_next = PH_HDR;
                        end
                    end else if (short_cnt > cfg.max_len) begin
                        produces           = 1'b1;
                        res_c.frame_status = ST_LEN;
                    end else begin
                        left_next  = {4'b0, in_byte_reg[3:0]};
                        phase_next = (in_byte_reg[3:0] != 4'd0) ? PH_PAY : PH_CHK;
                    end
                end
                PH_HDR: begin
                    sum_next = sum_add;
                    if (hidx_reg < HDR_LAST) begin
                        hidx_next = hidx_reg + 2'd1;
                    end else begin
                        hidx_next = 2'd0;
                        // A zero extended count is treated as a length error.
                        if (in_byte_reg == 8'd0 || in_byte_reg > cfg.max_len) begin
                            produces           = 1'b1;
                            res_c.frame_status = ST_LEN;
                        end else begin
                            left_next  = ext_body;
                            phase_next = (ext_body != 8'd0) ? PH_PAY : PH_CHK;
                        end
                    end
                end
                PH_PAY: begin
                    sum_next           = sum_add;
                    produces           = 1'b1;
                    res_c.payload_byte = in_byte_reg;
                    left_next          = left_dec;
                    if (left_dec == 8'd0) begin
                        phase_next = PH_CHK;
                    end
                end
                PH_CHK: begin
                    produces           = 1'b1;
                    res_c.frame_status = (sum_add == SUM_GOOD) ? ST_OK : ST_SUM;
                end
                default: begin
                    if (in_byte_reg != cfg.ack_code) begin
                        produces           = 1'b1;
                        res_c.frame_status = ST_ACK;
                    end else begin
                        sum_next   = 8'd0;
                        left_next  = 8'd0;
                        hidx_next  = 2'd0;
                        phase_next = PH_LEN;
                    end
                end
            endcase
        end

        // Every status result ends the frame and returns to the ack wait.
        if (produces && (in_tmo_reg || phase_reg != PH_PAY)) begin
            res_c.is_status     = 1'b1;
            res_c.last_of_frame = 1'b1;
            phase_next          = PH_ACK;
            sum_next            = 8'd0;
            left_next           = 8'd0;
            hidx_next           = 2'd0;
        end
    end

    assign advance   = in_valid_reg && (res_ready || !produces);
    assign s_ready   = !in_valid_reg || advance;
    assign res_valid = in_valid_reg && produces;
    assign res       = res_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_ACK;
            sum_reg      <= 8'd0;
            left_reg     <= 8'd0;
            hidx_reg     <= 2'd0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                phase_reg <= phase_next;
                sum_reg   <= sum_next;
                left_reg  <= left_next;
                hidx_reg  <= hidx_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
            in_tmo_reg  <= s_rx_timeout;
        end
    end

endmodule

// ===== hdl/rrd_out_stage.sv =====
// Result register that holds one result until the receiver takes it.
module rrd_out_stage
    import rrd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        res_valid,
    output logic        res_ready,
    input  rrd_result_t res,
    output logic        m_valid,
    input  logic        m_ready,
    output rrd_result_t m_res
);

    logic        valid_reg;
    rrd_result_t data_reg;

    assign res_ready = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_res     = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            data_reg <= res;
        end
    end

endmodule

// ===== hdl/radio_response_deframer_top.sv =====
// Radio response deframer: takes reply bytes and delivers payload bytes and frame status.
//
// Input channel (s_valid/s_ready) carries one received byte and a timeout flag per
// transaction. Output channel (m_valid/m_ready) carries a payload byte or an
// end-of-frame status; ack, header and length bytes give none unless they end the frame.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
// acknowledge code (index 0) and the length limit (index 1); it is always ready.
// A byte is taken into an input register and parsed by the frame state machine; its
// result is taken into the output register once that register can take it, which
// raises m_valid. One byte per cycle is sustained while the receiver takes every
// result; the frame state (phase, running sum, byte count) updates once per byte.
// When the receiver stalls, the output register holds its result and the input
// register still takes one more byte; bytes that produce no result keep flowing.
// Synchronous active-low reset empties both registers, returns the parser to the
// acknowledge wait and restores the default configuration.
module radio_response_deframer_top
    import rrd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_rx_byte,
    input  logic                 s_rx_timeout,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_payload_byte,
    output logic                 m_is_status,
    output logic [2:0]           m_frame_status,
    output logic                 m_last_of_frame,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    rrd_cfg_t    cfg;
    logic        res_valid;
    logic        res_ready;
    rrd_result_t res;
    rrd_result_t m_res;

    rrd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rrd_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .s_rx_timeout (s_rx_timeout),
        .res_ready    (res_ready),
        .res_valid    (res_valid),
        .res          (res)
    );

    rrd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_payload_byte  = m_res.payload_byte;
    assign m_is_status     = m_res.is_status;
    assign m_frame_status  = m_res.frame_status;
    assign m_last_of_frame = m_res.last_of_frame;

`ifndef ASSERT_OFF
    a_status_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_status == m_last_of_frame))
        else $error("status result and end-of-frame flag disagree");

    a_payload_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_is_status) |-> (m_frame_status == ST_OK))
        else $error("payload result carries a nonzero status");

    a_status_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_status) |-> (m_payload_byte == 8'd0 && m_frame_status <= ST_TMO))
        else $error("status result carries data or an undefined code");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_payload_byte)
            && $stable(m_is_status) && $stable(m_frame_status) && $stable(m_last_of_frame)))
        else $error("stalled result changed before it was taken");
`endif

endmodule

// ===== verif/tb_radio_response_deframer_top.sv =====
// Self-checking testbench for the radio response deframer top level.
module tb_radio_response_deframer_top;
    import rrd_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_ITEMS    = 300;
    localparam int NUM_SETTINGS   = 6;
    localparam int DIR_ROWS       = 25;
    localparam int SETTLE_CYCLES  = 4;

    typedef enum logic [2:0] {WAIT_ACK, WAIT_LEN, EXT_HDR, BODY, CHECKSUM} deframe_phase_t;
    typedef enum logic [1:0] {ROW_PRED, ROW_NONE, ROW_RES} row_kind_t;

    typedef struct packed {
        logic [7:0] b;
        logic       tmo;
        row_kind_t  kind;
        logic [2:0] code;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_rx_byte = '0;
    logic                 s_rx_timeout = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [7:0]           m_payload_byte;
    logic                 m_is_status;
    logic [2:0]           m_frame_status;
    logic                 m_last_of_frame;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data = '0;

    // Row kind and typed status travel beside the payload of the current transaction.
    row_kind_t  cur_kind = ROW_PRED;
    logic [2:0] cur_code = ST_OK;
    bit         no_idle = 1'b0;

    // Predictor state and its own copy of the registers.
    deframe_phase_t pr_phase;
    logic [7:0]     pr_sum;
    logic [7:0]     pr_left;
    logic [1:0]     pr_hidx;
    logic [7:0]     pr_ack;
    logic [7:0]     pr_max;

    // Register values the frame generator builds against.
    logic [7:0] gen_ack;
    logic [7:0] gen_max;

    rrd_result_t expected_out_q[$];
    stim_row_t   frame_q[$];
    stim_row_t   dir_tab[DIR_ROWS];

    int fail_count = 0;
    int items_accepted = 0;
    int payload_seen = 0;
    int status_seen[5];
    int idle_cycles = 0;
    int phase_items;

    always #10 aclk = ~aclk;

    radio_response_deframer_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .s_rx_timeout    (s_rx_timeout),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload_byte  (m_payload_byte),
        .m_is_status     (m_is_status),
        .m_frame_status  (m_frame_status),
        .m_last_of_frame (m_last_of_frame),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    function automatic rrd_result_t status_result(input logic [2:0] code);
        rrd_result_t r;
        r = '0;
        r.is_status = 1'b1;
        r.frame_status = code;
        r.last_of_frame = 1'b1;
        return r;
    endfunction

    function automatic stim_row_t dir_row(input logic [7:0] b, input logic tmo,
                                          input row_kind_t kind, input logic [2:0] code);
        stim_row_t r;
        r.b = b;
        r.tmo = tmo;
        r.kind = kind;
        r.code = code;
        return r;
    endfunction

    function automatic void clear_deframer();
        pr_phase = WAIT_ACK;
        pr_sum = '0;
        pr_left = '0;
        pr_hidx = '0;
    endfunction

    // Advances the predicted frame state by one byte and returns the result it causes.
    function automatic void deframe_byte(input logic [7:0] b, input logic tmo,
                                         output logic has, output rrd_result_t res);
        logic       done;
        logic [2:0] code;
        logic [7:0] n;
        done = 1'b0;
        code = ST_OK;
        has = 1'b0;
        res = '0;
        if (tmo) begin
            done = 1'b1;
            code = ST_TMO;
        end else begin
            case (pr_phase)
                WAIT_LEN: begin
                    pr_sum = b;
                    if (b == EXT_MARK) begin
                        if (EXT_HDR_LEN > pr_max) begin
                            done = 1'b1;
                            code = ST_LEN;
                        end else begin
                            pr_hidx = '0;
                            pr_phase = EXT_HDR;
                        end
                    end else begin
                        n = {4'd0, b[3:0] & NIB_MASK} + 8'd1;
                        if (n > pr_max) begin
                            done = 1'b1;
                            code = ST_LEN;
                        end else begin
                            pr_left = n - 8'd1;
                            pr_phase = (pr_left != 0) ? BODY : CHECKSUM;
                        end
                    end
                end
                EXT_HDR: begin
                    pr_sum = pr_sum + b;
                    if (pr_hidx < HDR_LAST) begin
                        pr_hidx = pr_hidx + 2'd1;
                    end else begin
                        pr_hidx = '0;
                        if (b == 8'd0 || b > pr_max) begin
                            done = 1'b1;
                            code = ST_LEN;
                        end else begin
                            pr_left = b - 8'd1;
                            pr_phase = (pr_left != 0) ? BODY : CHECKSUM;
                        end
                    end
                end
                BODY: begin
                    pr_sum = pr_sum + b;
                    has = 1'b1;
                    res.payload_byte = b;
                    pr_left = pr_left - 8'd1;
                    if (pr_left == 0)
                        pr_phase = CHECKSUM;
                end
                CHECKSUM: begin
                    pr_sum = pr_sum + b;
                    done = 1'b1;
                    code = (pr_sum == SUM_GOOD) ? ST_OK : ST_SUM;
                end
                default: begin
                    if (b != pr_ack) begin
                        done = 1'b1;
                        code = ST_ACK;
                    end else begin
                        clear_deframer();
                        pr_phase = WAIT_LEN;
                    end
                end
            endcase
        end
        if (done) begin
            has = 1'b1;
            res = status_result(code);
            clear_deframer();
        end
    endfunction

    // Input transactions feed the predictor, output transactions are checked in order.
    always @(posedge aclk) begin : scoreboard
        logic        has;
        logic        active;
        rrd_result_t want;
        rrd_result_t got;
        if (!aresetn) begin
            clear_deframer();
            pr_ack = ACK_CODE_RESET;
            pr_max = MAX_LEN_RESET;
            idle_cycles = 0;
        end else begin
            active = 1'b0;
            if (cfg_valid && cfg_ready) begin
                active = 1'b1;
                case (cfg_index)
                    CFG_ACK_CODE: pr_ack = cfg_data;
                    CFG_MAX_LEN:  pr_max = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                active = 1'b1;
                items_accepted++;
                deframe_byte(s_rx_byte, s_rx_timeout, has, want);
                if (cur_kind == ROW_RES)
                    expected_out_q.push_back(status_result(cur_code));
                else if (cur_kind == ROW_PRED && has)
                    expected_out_q.push_back(want);
            end
            if (m_valid && m_ready) begin
                active = 1'b1;
                got.payload_byte = m_payload_byte;
                got.is_status = m_is_status;
                got.frame_status = m_frame_status;
                got.last_of_frame = m_last_of_frame;
                if (got.is_status === 1'b1 && got.frame_status <= ST_TMO)
                    status_seen[got.frame_status]++;
                else
                    payload_seen++;
                if (expected_out_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: byte %02h status %0b code %0d last %0b",
                                 got.payload_byte, got.is_status, got.frame_status,
                                 got.last_of_frame);
                end else begin
                    want = expected_out_q.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: expected byte %02h status %0b code %0d ",
                                      "last %0b, got byte %02h status %0b code %0d last %0b"},
                                     want.payload_byte, want.is_status, want.frame_status,
                                     want.last_of_frame, got.payload_byte, got.is_status,
                                     got.frame_status, got.last_of_frame);
                    end
                end
            end
            idle_cycles = active ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("radio_response_deframer_top regression: fail");
                $finish;
            end
        end
    end

    // Result side: a random stall before each transaction, none while no_idle is set.
    initial begin : result_sink
        int stall;
        @(negedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_row(input stim_row_t r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_rx_byte = r.b;
        s_rx_timeout = r.tmo;
        cur_kind = r.kind;
        cur_code = r.code;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (expected_out_q.size() != 0) @(negedge aclk);
    endtask

    task automatic set_config(input logic [7:0] ack, input logic [7:0] max_len);
        int k;
        for (k = 0; k < 2; k++) begin
            cfg_valid = 1'b1;
            cfg_index = (k == 0) ? CFG_ACK_CODE : CFG_MAX_LEN;
            cfg_data = (k == 0) ? ack : max_len;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            @(negedge aclk);
        end
        cfg_valid = 1'b0;
        gen_ack = ack;
        gen_max = max_len;
    endtask

    // Mostly well-formed replies with random content; some noise, bad acks,
    // out-of-range lengths, corrupted checksums and timeouts.
    task automatic build_frame();
        int         pick;
        int         body;
        int         pos;
        logic [7:0] sum;
        logic [7:0] cnt;
        logic [7:0] chk;
        stim_row_t  r;
        frame_q.delete();
        pick = $urandom_range(0, 99);
        r = dir_row(8'h00, 1'b0, ROW_PRED, ST_OK);
        if (pick < 6) begin
            repeat ($urandom_range(1, 4)) begin
                r.b = 8'($urandom);
                r.tmo = ($urandom_range(0, 3) == 0);
                frame_q.push_back(r);
            end
        end else begin
            r.b = (pick < 14) ? 8'($urandom) : gen_ack;
            frame_q.push_back(r);
            if (pick < 44) begin
                r.b = EXT_MARK;
                frame_q.push_back(r);
                sum = EXT_MARK;
                repeat (2) begin
                    r.b = 8'($urandom);
                    sum += r.b;
                    frame_q.push_back(r);
                end
                pos = $urandom_range(0, 99);
                if (pos < 5)
                    cnt = 8'd0;
                else if (pos < 15)
                    cnt = 8'($urandom);
                else
                    cnt = 8'($urandom_range(1, (gen_max < 24) ? gen_max : 24));
                r.b = cnt;
                sum += cnt;
                frame_q.push_back(r);
                body = (cnt == 0) ? 0 : cnt - 1;
            end else begin
                r.b = 8'($urandom_range(0, 254));
                frame_q.push_back(r);
                sum = r.b;
                body = r.b[3:0];
            end
            repeat (body) begin
                r.b = 8'($urandom);
                sum += r.b;
                frame_q.push_back(r);
            end
            chk = SUM_GOOD - sum;
            if ($urandom_range(0, 9) == 0)
                chk ^= 8'($urandom_range(1, 255));
            r.b = chk;
            frame_q.push_back(r);
            if ($urandom_range(0, 19) == 0) begin
                pos = $urandom_range(0, frame_q.size() - 1);
                r = frame_q[pos];
                r.tmo = 1'b1;
                frame_q[pos] = r;
            end
        end
    endtask

    initial begin : stimulus
        int         i;
        int         p;
        logic [7:0] ack;
        logic [7:0] max_len;
        gen_ack = ACK_CODE_RESET;
        gen_max = MAX_LEN_RESET;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        dir_tab[0]  = dir_row(8'hFF, 1'b1, ROW_RES,  ST_TMO);  // timeout while idle
        dir_tab[1]  = dir_row(8'h00, 1'b0, ROW_RES,  ST_ACK);
        dir_tab[2]  = dir_row(8'h50, 1'b0, ROW_NONE, ST_OK);
        dir_tab[3]  = dir_row(8'hF0, 1'b0, ROW_NONE, ST_OK);   // no payload, checksum next
        dir_tab[4]  = dir_row(8'h00, 1'b0, ROW_RES,  ST_SUM);
        dir_tab[5]  = dir_row(8'h50, 1'b0, ROW_NONE, ST_OK);
        dir_tab[6]  = dir_row(8'h02, 1'b0, ROW_NONE, ST_OK);
        dir_tab[7]  = dir_row(8'h00, 1'b0, ROW_PRED, ST_OK);
        dir_tab[8]  = dir_row(8'hFF, 1'b0, ROW_PRED, ST_OK);
        dir_tab[9]  = dir_row(8'hFE, 1'b0, ROW_PRED, ST_OK);
        dir_tab[10] = dir_row(8'h50, 1'b0, ROW_NONE, ST_OK);
        dir_tab[11] = dir_row(8'hFF, 1'b0, ROW_NONE, ST_OK);   // extended header
        dir_tab[12] = dir_row(8'h00, 1'b0, ROW_NONE, ST_OK);
        dir_tab[13] = dir_row(8'h00, 1'b0, ROW_NONE, ST_OK);
        dir_tab[14] = dir_row(8'h02, 1'b0, ROW_NONE, ST_OK);
        dir_tab[15] = dir_row(8'hAA, 1'b0, ROW_PRED, ST_OK);
        dir_tab[16] = dir_row(8'h54, 1'b0, ROW_PRED, ST_OK);
        dir_tab[17] = dir_row(8'h50, 1'b0, ROW_NONE, ST_OK);
        dir_tab[18] = dir_row(8'hFF, 1'b0, ROW_NONE, ST_OK);
        dir_tab[19] = dir_row(8'h12, 1'b0, ROW_NONE, ST_OK);
        dir_tab[20] = dir_row(8'h34, 1'b0, ROW_NONE, ST_OK);
        dir_tab[21] = dir_row(8'h00, 1'b0, ROW_RES,  ST_LEN);  // extended count of zero
        dir_tab[22] = dir_row(8'h50, 1'b0, ROW_NONE, ST_OK);
        dir_tab[23] = dir_row(8'h05, 1'b0, ROW_NONE, ST_OK);
        dir_tab[24] = dir_row(8'h77, 1'b1, ROW_RES,  ST_TMO);  // timeout inside the payload
        for (i = 0; i < DIR_ROWS; i++)
            send_row(dir_tab[i]);

        for (p = 0; p < NUM_SETTINGS; p++) begin
            case (p)
                0: begin ack = ACK_CODE_RESET; max_len = MAX_LEN_RESET; end
                1: begin ack = 8'h00; max_len = 8'd1; end
                2: begin ack = 8'hFF; max_len = 8'd2; end
                3: begin ack = 8'h3C; max_len = 8'd3; end
                4: begin ack = 8'hA5; max_len = 8'd16; end
                default: begin ack = ACK_CODE_RESET; max_len = 8'd200; end
            endcase
            // Registers change only once the block has gone quiet.
            wait_drained();
            repeat (SETTLE_CYCLES) @(negedge aclk);
            set_config(ack, max_len);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                no_idle = ($urandom_range(0, 4) == 0);
                build_frame();
                foreach (frame_q[i])
                    send_row(frame_q[i]);
                phase_items += frame_q.size();
                if ($urandom_range(0, 24) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES * 2) @(negedge aclk);
        if (expected_out_q.size() != 0) begin
            fail_count += expected_out_q.size();
            $display("%0d expected results never arrived", expected_out_q.size());
        end
        $display("Covered %0d input bytes over %0d register settings; %0d payload bytes seen.",
                 items_accepted, NUM_SETTINGS, payload_seen);
        $display("Frame status seen: ok %0d, ack %0d, length %0d, checksum %0d, timeout %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (fail_count == 0) begin
            $display("radio_response_deframer_top regression: pass");
        end else begin
            $display("radio_response_deframer_top regression: fail");
        end
        $finish;
    end

endmodule
